>>> rtl/fssm_pkg.sv
package fssm_pkg;

    // Stem slots on the ports; stems at or above NUM_STEMS are ignored.
    localparam int STEM_SLOTS = 4;
    localparam int NUM_STEMS  = 4;

    localparam int SAMPLE_W = 16;
    localparam int Q14_W    = 16;
    localparam int MIX_W    = 15;
    localparam int COEF_W   = 30;                  // gain * pan gain, Q2.28 unsigned
    localparam int PROD_W   = SAMPLE_W + COEF_W;   // sample * coef, signed
    localparam int WET_W    = PROD_W + 2;          // sum over four stems
    localparam int ACC_W    = 64;
    localparam int ROUND_SHIFT = 42;
    localparam int Q_W      = ACC_W - ROUND_SHIFT;

    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam logic [MIX_W-1:0] UNITY_Q14 = 15'd16384;
    localparam logic [63:0]      GAINS_RESET = 64'h4000_4000_4000_4000;

    typedef enum logic [2:0] {
        REG_GAINS   = 3'd0,
        REG_PANS    = 3'd1,
        REG_MUTE    = 3'd2,
        REG_SOLO    = 3'd3,
        REG_PRESENT = 3'd4,
        REG_LOADED  = 3'd5,
        REG_PLAYING = 3'd6,
        REG_DRY_MIX = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [63:0]           gains;
        logic [63:0]           pans;
        logic [STEM_SLOTS-1:0] mute;
        logic [STEM_SLOTS-1:0] solo;
        logic [STEM_SLOTS-1:0] present;
        logic                  loaded;
        logic                  playing;
        logic [MIX_W-1:0]      dry_mix;
    } t_cfg;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [COEF_W-1:0]          t_coef;

endpackage

>>> rtl/fssm_regs.sv
module fssm_regs
    import fssm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[5:3]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_GAINS:   n_cfg.gains   = pwdata;
                REG_PANS:    n_cfg.pans    = pwdata;
                REG_MUTE:    n_cfg.mute    = pwdata[STEM_SLOTS-1:0];
                REG_SOLO:    n_cfg.solo    = pwdata[STEM_SLOTS-1:0];
                REG_PRESENT: n_cfg.present = pwdata[STEM_SLOTS-1:0];
                REG_LOADED:  n_cfg.loaded  = pwdata[0];
                REG_PLAYING: n_cfg.playing = pwdata[0];
                REG_DRY_MIX: n_cfg.dry_mix = pwdata[MIX_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gains   <= GAINS_RESET;
            r_cfg.pans    <= '0;
            r_cfg.mute    <= '0;
            r_cfg.solo    <= '0;
            r_cfg.present <= '0;
            r_cfg.loaded  <= 1'b0;
            r_cfg.playing <= 1'b0;
            r_cfg.dry_mix <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_GAINS:   prdata = r_cfg.gains;
            REG_PANS:    prdata = r_cfg.pans;
            REG_MUTE:    prdata = APB_DW'(r_cfg.mute);
            REG_SOLO:    prdata = APB_DW'(r_cfg.solo);
            REG_PRESENT: prdata = APB_DW'(r_cfg.present);
            REG_LOADED:  prdata = APB_DW'(r_cfg.loaded);
            REG_PLAYING: prdata = APB_DW'(r_cfg.playing);
            REG_DRY_MIX: prdata = APB_DW'(r_cfg.dry_mix);
            default:     prdata = '0;
        endcase
    end

endmodule

>>> rtl/fssm_coef.sv
module fssm_coef
    import fssm_pkg::*;
(
    input  logic                   i_clk,
    input  t_cfg                   i_cfg,
    output t_coef [STEM_SLOTS-1:0] o_coef_l,
    output t_coef [STEM_SLOTS-1:0] o_coef_r
);

    t_coef [STEM_SLOTS-1:0] r_coef_l;
    t_coef [STEM_SLOTS-1:0] r_coef_r;
    t_coef [STEM_SLOTS-1:0] n_coef_l;
    t_coef [STEM_SLOTS-1:0] n_coef_r;

    logic                        any_solo;
    logic [STEM_SLOTS-1:0]       active;
    logic signed [SAMPLE_W-1:0]  pan_raw [STEM_SLOTS];
    logic signed [SAMPLE_W:0]    pan_c   [STEM_SLOTS];
    logic [MIX_W-1:0]            pl      [STEM_SLOTS];
    logic [MIX_W-1:0]            pr      [STEM_SLOTS];
    logic [Q14_W-1:0]            gain    [STEM_SLOTS];

    always_comb begin
        any_solo = 1'b0;
        for (int i = 0; i < STEM_SLOTS; i++) begin
            if (i < NUM_STEMS && i_cfg.solo[i]) any_solo = 1'b1;
        end
        for (int i = 0; i < STEM_SLOTS; i++) begin
            active[i] = (i < NUM_STEMS) && i_cfg.playing && i_cfg.present[i]
                        && !i_cfg.mute[i] && (!any_solo || i_cfg.solo[i]);
            gain[i]    = i_cfg.gains[16*i +: 16];
            pan_raw[i] = $signed(i_cfg.pans[16*i +: 16]);
            // linear pan law, pan clamped to +/- unity
            if (pan_raw[i] > 16'sd16384)
                pan_c[i] = 17'sd16384;
            else if (pan_raw[i] < -16'sd16384)
                pan_c[i] = -17'sd16384;
            else
                pan_c[i] = 17'(pan_raw[i]);
            pl[i] = (pan_c[i] <= 17'sd0) ? UNITY_Q14 : MIX_W'(17'sd16384 - pan_c[i]);
            pr[i] = (pan_c[i] >= 17'sd0) ? UNITY_Q14 : MIX_W'(17'sd16384 + pan_c[i]);
            if (active[i]) begin
                n_coef_l[i] = COEF_W'(gain[i]) * COEF_W'(pl[i]);
                n_coef_r[i] = COEF_W'(gain[i]) * COEF_W'(pr[i]);
            end else begin
                n_coef_l[i] = '0;
                n_coef_r[i] = '0;
            end
        end
    end

    // Tracks regs each cycle; user writes cfg only if idle, unchecked.
    always_ff @(posedge i_clk) begin
        r_coef_l <= n_coef_l;
        r_coef_r <= n_coef_r;
    end

    assign o_coef_l = r_coef_l;
    assign o_coef_r = r_coef_r;

endmodule

>>> rtl/fssm_datapath.sv
module fssm_datapath
    import fssm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_sample [STEM_SLOTS-1:0] i_left,
    input  t_sample [STEM_SLOTS-1:0] i_right,
    input  t_sample                  i_dry_left,
    input  t_sample                  i_dry_right,
    input  t_cfg                     i_cfg,
    input  t_coef [STEM_SLOTS-1:0]   i_coef_l,
    input  t_coef [STEM_SLOTS-1:0]   i_coef_r,
    output logic                     o_valid,
    output t_sample                  o_mix_left,
    output t_sample                  o_mix_right
);

    // valid per stage: 1 capture, 2 products, 3 sums, 4 scale, 5 round
    logic [4:0] r_v;

    t_sample [STEM_SLOTS-1:0] r1_left;
    t_sample [STEM_SLOTS-1:0] r1_right;
    t_sample                  r1_dry_l;
    t_sample                  r1_dry_r;

    logic signed [PROD_W-1:0] r2_pl [STEM_SLOTS];
    logic signed [PROD_W-1:0] r2_pr [STEM_SLOTS];
    t_sample                  r2_dry_l;
    t_sample                  r2_dry_r;

    logic signed [WET_W-1:0]  r3_wet_l;
    logic signed [WET_W-1:0]  r3_wet_r;
    logic signed [31:0]       r3_dry_l;
    logic signed [31:0]       r3_dry_r;

    logic signed [ACC_W-1:0]  r4_wet_l;
    logic signed [ACC_W-1:0]  r4_wet_r;
    logic signed [ACC_W-1:0]  r4_dry_l;
    logic signed [ACC_W-1:0]  r4_dry_r;

    t_sample                  r_out_l;
    t_sample                  r_out_r;

    logic [MIX_W-1:0]         dm;
    logic [MIX_W-1:0]         wet_scale;
    logic signed [WET_W-1:0]  n_wet_l;
    logic signed [WET_W-1:0]  n_wet_r;
    logic signed [ACC_W-1:0]  acc_l;
    logic signed [ACC_W-1:0]  acc_r;
    t_sample                  n_out_l;
    t_sample                  n_out_r;

    function automatic t_sample sat16(input logic signed [Q_W-1:0] q);
        if (q > Q_W'(32767))
            sat16 = 16'sh7FFF;
        else if (q < -Q_W'(32768))
            sat16 = 16'sh8000;
        else
            sat16 = q[SAMPLE_W-1:0];
    endfunction

    assign dm        = (i_cfg.dry_mix > UNITY_Q14) ? UNITY_Q14 : i_cfg.dry_mix;
    assign wet_scale = UNITY_Q14 - dm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_comb begin
        n_wet_l = '0;
        n_wet_r = '0;
        for (int i = 0; i < STEM_SLOTS; i++) begin
            n_wet_l = n_wet_l + WET_W'(r2_pl[i]);
            n_wet_r = n_wet_r + WET_W'(r2_pr[i]);
        end
    end

    // add half an LSB, floor by arithmetic shift
    assign acc_l = r4_wet_l + r4_dry_l + (ACC_W'(1) <<< (ROUND_SHIFT - 1));
    assign acc_r = r4_wet_r + r4_dry_r + (ACC_W'(1) <<< (ROUND_SHIFT - 1));

    always_comb begin
        if (i_cfg.loaded) begin
            n_out_l = sat16(acc_l[ACC_W-1:ROUND_SHIFT]);
            n_out_r = sat16(acc_r[ACC_W-1:ROUND_SHIFT]);
        end else begin
            n_out_l = '0;
            n_out_r = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_left  <= i_left;
        r1_right <= i_right;
        r1_dry_l <= i_dry_left;
        r1_dry_r <= i_dry_right;

        for (int i = 0; i < STEM_SLOTS; i++) begin
            r2_pl[i] <= $signed(r1_left[i])  * $signed({1'b0, i_coef_l[i]});
            r2_pr[i] <= $signed(r1_right[i]) * $signed({1'b0, i_coef_r[i]});
        end
        r2_dry_l <= r1_dry_l;
        r2_dry_r <= r1_dry_r;

        r3_wet_l <= n_wet_l;
        r3_wet_r <= n_wet_r;
        r3_dry_l <= $signed(r2_dry_l) * $signed({1'b0, dm});
        r3_dry_r <= $signed(r2_dry_r) * $signed({1'b0, dm});

        r4_wet_l <= r3_wet_l * $signed({1'b0, wet_scale});
        r4_wet_r <= r3_wet_r * $signed({1'b0, wet_scale});
        r4_dry_l <= ACC_W'(r3_dry_l) <<< 28;
        r4_dry_r <= ACC_W'(r3_dry_r) <<< 28;

        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
    end

    assign o_valid     = r_v[4];
    assign o_mix_left  = r_out_l;
    assign o_mix_right = r_out_r;

endmodule

>>> rtl/four_stem_stereo_mixer_top.sv
// channel   | transfer when                          | payload
// ----------+----------------------------------------+------------------------------------
// frame in  | start && !busy at rising edge          | i_stem0..3_left/right, i_dry_*
// mix out   | o_mix_valid high for one cycle         | o_mix_left, o_mix_right
// config    | psel && penable && pwrite && pready    | paddr (reg * 8), pwdata (64 bit)
//
// One frame per cycle in; each result passes through the stage chain capture, stem
// products, stem sum, wet scale, round/saturate.
// busy is always low: the pipeline never stalls and the receiver cannot stall it.
// Synchronous active-low reset clears the valid chain and loads register defaults.
// Coefficients are registered from config; user writes config only while idle, unchecked.
module four_stem_stereo_mixer_top
    import fssm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  i_stem0_left,
    input  logic signed [15:0]  i_stem0_right,
    input  logic signed [15:0]  i_stem1_left,
    input  logic signed [15:0]  i_stem1_right,
    input  logic signed [15:0]  i_stem2_left,
    input  logic signed [15:0]  i_stem2_right,
    input  logic signed [15:0]  i_stem3_left,
    input  logic signed [15:0]  i_stem3_right,
    input  logic signed [15:0]  i_dry_left,
    input  logic signed [15:0]  i_dry_right,
    output logic                o_mix_valid,
    output logic signed [15:0]  o_mix_left,
    output logic signed [15:0]  o_mix_right,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_cfg                   cfg;
    t_coef [STEM_SLOTS-1:0] coef_l;
    t_coef [STEM_SLOTS-1:0] coef_r;
    t_sample [STEM_SLOTS-1:0] left;
    t_sample [STEM_SLOTS-1:0] right;
    logic                   in_xfer;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    assign left  = {i_stem3_left,  i_stem2_left,  i_stem1_left,  i_stem0_left};
    assign right = {i_stem3_right, i_stem2_right, i_stem1_right, i_stem0_right};

    fssm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fssm_coef u_coef (
        .i_clk    (i_clk),
        .i_cfg    (cfg),
        .o_coef_l (coef_l),
        .o_coef_r (coef_r)
    );

    fssm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_xfer),
        .i_left      (left),
        .i_right     (right),
        .i_dry_left  (i_dry_left),
        .i_dry_right (i_dry_right),
        .i_cfg       (cfg),
        .i_coef_l    (coef_l),
        .i_coef_r    (coef_r),
        .o_valid     (o_mix_valid),
        .o_mix_left  (o_mix_left),
        .o_mix_right (o_mix_right)
    );

endmodule

>>> rtl/fssm_checker.sv
module fssm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_mix_valid,
    input logic pready
);

    // every frame transfer yields exactly one result
    a_xfer_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_mix_valid)
        else $error("frame transfer without result");

    a_result_from_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mix_valid |-> $past(start && !busy, 5))
        else $error("result without matching frame transfer");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_mix_valid)
        else $error("result strobe right after reset");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind four_stem_stereo_mixer_top fssm_checker u_fssm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_mix_valid (o_mix_valid),
    .pready      (pready)
);

>>> tb/fssm_mix_checker.sv
`timescale 1ns / 1ps

module fssm_mix_checker
    import fssm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_sample            i_stem0_left,
    input  t_sample            i_stem0_right,
    input  t_sample            i_stem1_left,
    input  t_sample            i_stem1_right,
    input  t_sample            i_stem2_left,
    input  t_sample            i_stem2_right,
    input  t_sample            i_stem3_left,
    input  t_sample            i_stem3_right,
    input  t_sample            i_dry_left,
    input  t_sample            i_dry_right,
    input  logic               i_mix_valid,
    input  t_sample            i_mix_left,
    input  t_sample            i_mix_right,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [APB_AW-1:0]  i_paddr,
    input  logic [APB_DW-1:0]  i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam longint UNITY = longint'(UNITY_Q14);

    typedef struct {
        t_sample left;
        t_sample right;
    } t_mix;

    t_cfg    cfg_model;
    t_mix    mix_expect_q[$];
    t_sample frame_smp [10];
    int      fail_cnt = 0;

    function automatic t_sample round_sat(input longint v);
        longint q;
        q = (v + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return t_sample'(q[15:0]);
    endfunction

    function automatic t_mix predict_mix(input t_cfg c, input t_sample smp [10]);
        t_mix   m;
        longint wet_l, wet_r, dm, g, p, pl, pr, acc_l, acc_r;
        logic   any_solo;
        wet_l = 0;
        wet_r = 0;
        m.left  = '0;
        m.right = '0;
        if (!c.loaded) return m;
        dm = c.dry_mix;
        if (dm > UNITY) dm = UNITY;
        if (c.playing) begin
            any_solo = |c.solo[NUM_STEMS-1:0];
            for (int s = 0; s < NUM_STEMS; s++) begin
                if (c.present[s] && !c.mute[s] && (!any_solo || c.solo[s])) begin
                    g = c.gains[16*s +: 16];
                    p = $signed(c.pans[16*s +: 16]);
                    if (p > UNITY) p = UNITY;
                    if (p < -UNITY) p = -UNITY;
                    pl = (p <= 0) ? UNITY : UNITY - p;
                    pr = (p >= 0) ? UNITY : UNITY + p;
                    wet_l += longint'(smp[2*s]) * (g * pl);
                    wet_r += longint'(smp[2*s+1]) * (g * pr);
                end
            end
        end
        acc_l = wet_l * (UNITY - dm) + (longint'(smp[8]) * dm) * (longint'(1) <<< 28);
        acc_r = wet_r * (UNITY - dm) + (longint'(smp[9]) * dm) * (longint'(1) <<< 28);
        m.left  = round_sat(acc_l);
        m.right = round_sat(acc_r);
        return m;
    endfunction

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin : watch
        t_mix want;
        if (!i_rst_n) begin
            cfg_model = '0;
            cfg_model.gains = GAINS_RESET;
            mix_expect_q.delete();
        end else begin
            if (i_mix_valid) begin
                if (mix_expect_q.size() == 0) begin
                    report($sformatf("unexpected result left %0d right %0d",
                                     i_mix_left, i_mix_right));
                end else begin
                    want = mix_expect_q.pop_front();
                    if (i_mix_left !== want.left)
                        report($sformatf("mix_left got %0d expected %0d",
                                         i_mix_left, want.left));
                    if (i_mix_right !== want.right)
                        report($sformatf("mix_right got %0d expected %0d",
                                         i_mix_right, want.right));
                end
            end
            if (i_start && !i_busy) begin
                frame_smp[0] = i_stem0_left;
                frame_smp[1] = i_stem0_right;
                frame_smp[2] = i_stem1_left;
                frame_smp[3] = i_stem1_right;
                frame_smp[4] = i_stem2_left;
                frame_smp[5] = i_stem2_right;
                frame_smp[6] = i_stem3_left;
                frame_smp[7] = i_stem3_right;
                frame_smp[8] = i_dry_left;
                frame_smp[9] = i_dry_right;
                mix_expect_q.push_back(predict_mix(cfg_model, frame_smp));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_AW-1:3]))
                    REG_GAINS:   cfg_model.gains   = i_pwdata;
                    REG_PANS:    cfg_model.pans    = i_pwdata;
                    REG_MUTE:    cfg_model.mute    = i_pwdata[STEM_SLOTS-1:0];
                    REG_SOLO:    cfg_model.solo    = i_pwdata[STEM_SLOTS-1:0];
                    REG_PRESENT: cfg_model.present = i_pwdata[STEM_SLOTS-1:0];
                    REG_LOADED:  cfg_model.loaded  = i_pwdata[0];
                    REG_PLAYING: cfg_model.playing = i_pwdata[0];
                    REG_DRY_MIX: cfg_model.dry_mix = i_pwdata[MIX_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= mix_expect_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import fssm_pkg::*;

    localparam int MIX_LATENCY   = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 13;
    localparam int PHASE_FRAMES  = 52;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_sample           frame_drv [10] = '{default: '0};
    logic              o_mix_valid;
    t_sample           o_mix_left;
    t_sample           o_mix_right;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int      fail_count;
    int      pending;
    int      cycle_cnt = 0;
    t_sample cur_frame [10];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    four_stem_stereo_mixer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_stem0_left  (frame_drv[0]),
        .i_stem0_right (frame_drv[1]),
        .i_stem1_left  (frame_drv[2]),
        .i_stem1_right (frame_drv[3]),
        .i_stem2_left  (frame_drv[4]),
        .i_stem2_right (frame_drv[5]),
        .i_stem3_left  (frame_drv[6]),
        .i_stem3_right (frame_drv[7]),
        .i_dry_left    (frame_drv[8]),
        .i_dry_right   (frame_drv[9]),
        .o_mix_valid   (o_mix_valid),
        .o_mix_left    (o_mix_left),
        .o_mix_right   (o_mix_right),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fssm_mix_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_stem0_left  (frame_drv[0]),
        .i_stem0_right (frame_drv[1]),
        .i_stem1_left  (frame_drv[2]),
        .i_stem1_right (frame_drv[3]),
        .i_stem2_left  (frame_drv[4]),
        .i_stem2_right (frame_drv[5]),
        .i_stem3_left  (frame_drv[6]),
        .i_stem3_right (frame_drv[7]),
        .i_dry_left    (frame_drv[8]),
        .i_dry_right   (frame_drv[9]),
        .i_mix_valid   (o_mix_valid),
        .i_mix_left    (o_mix_left),
        .i_mix_right   (o_mix_right),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_sample rand_sample();
        t_sample v;
        case ($urandom_range(0, 7))
            0:       v = 16'sh7FFF;
            1:       v = t_sample'(16'h8000);
            2:       v = '0;
            3, 4:    v = t_sample'($urandom_range(0, 65535)) >>> $urandom_range(4, 14);
            default: v = t_sample'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h4000;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_pan();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h4000;
            2:       return 16'hC000;
            3:       return 16'h7FFF;
            4:       return 16'h8000;
            5:       return 16'($urandom_range(0, 32768) - 16384);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        for (int s = 0; s < STEM_SLOTS; s++) begin
            c.gains[16*s +: 16] = rand_gain();
            c.pans[16*s +: 16]  = rand_pan();
        end
        c.mute    = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
        c.solo    = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
        c.present = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(0, 15));
        c.loaded  = ($urandom_range(0, 7) != 0);
        c.playing = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 5))
            0:       c.dry_mix = 15'd0;
            1:       c.dry_mix = UNITY_Q14;
            2:       c.dry_mix = 15'h7FFF;
            3:       c.dry_mix = 15'($urandom_range(16385, 32767));
            default: c.dry_mix = 15'($urandom_range(0, 16384));
        endcase
        return c;
    endfunction

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain every outstanding result, then let the pipeline empty out.
    task automatic settle_idle();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (MIX_LATENCY) @(posedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        settle_idle();
        apb_write(REG_GAINS,   c.gains);
        apb_write(REG_PANS,    c.pans);
        apb_write(REG_MUTE,    APB_DW'(c.mute));
        apb_write(REG_SOLO,    APB_DW'(c.solo));
        apb_write(REG_PRESENT, APB_DW'(c.present));
        apb_write(REG_LOADED,  APB_DW'(c.loaded));
        apb_write(REG_PLAYING, APB_DW'(c.playing));
        apb_write(REG_DRY_MIX, APB_DW'(c.dry_mix));
    endtask

    // start stays high across back-to-back transfers; lowered only for a gap
    task automatic send_frame(input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int k = 0; k < 10; k++) frame_drv[k] <= cur_frame[k];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic fill_frame(input t_sample l, input t_sample r);
        for (int k = 0; k < 10; k += 2) begin
            cur_frame[k]   = l;
            cur_frame[k+1] = r;
        end
    endtask

    task automatic send_random(input int count, input int max_gap);
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 10; k++) cur_frame[k] = rand_sample();
            send_frame(max_gap);
        end
    endtask

    initial begin : stimulus
        t_cfg c;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // not loaded after reset: silence
        fill_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(4);
        fill_frame(t_sample'(16'h8000), t_sample'(16'h8000));
        send_frame(0);

        // paused: dry path only, incl. dry mix above unity and zero
        c = '0;
        c.gains   = GAINS_RESET;
        c.present = 4'hF;
        c.loaded  = 1'b1;
        c.dry_mix = UNITY_Q14;
        load_cfg(c);
        fill_frame(16'sh7FFF, t_sample'(16'h8000));
        send_frame(0);
        fill_frame(t_sample'(16'h8000), 16'sh7FFF);
        send_frame(1);
        fill_frame(-16'sd1, 16'sd1);
        send_frame(0);
        c.dry_mix = 15'h7FFF;
        load_cfg(c);
        fill_frame(t_sample'(16'h8000), 16'sh7FFF);
        send_frame(0);
        c.dry_mix = 15'd0;
        load_cfg(c);
        fill_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(0);

        // playing, max gains, pans at and beyond the rails: saturation
        c.playing = 1'b1;
        c.gains   = 64'hFFFF_FFFF_FFFF_FFFF;
        c.pans    = 64'h8000_7FFF_C000_4000;
        load_cfg(c);
        fill_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(0);
        fill_frame(t_sample'(16'h8000), t_sample'(16'h8000));
        send_frame(0);
        fill_frame(16'sh7FFF, t_sample'(16'h8000));
        send_frame(2);

        // soloed stem absent: every other stem drops out
        c.gains   = GAINS_RESET;
        c.pans    = 64'h0;
        c.mute    = 4'b0011;
        c.solo    = 4'b0100;
        c.present = 4'b1011;
        c.dry_mix = 15'd8192;
        load_cfg(c);
        send_random(2, 1);

        // soloed and muted stem, mixed pans
        c.mute    = 4'b1000;
        c.solo    = 4'b1001;
        c.present = 4'hF;
        c.pans    = 64'hE000_2000_C000_4000;
        c.dry_mix = 15'd4096;
        load_cfg(c);
        send_random(3, 0);

        // zero gains
        c.gains   = 64'h0;
        c.mute    = 4'h0;
        c.solo    = 4'h0;
        c.dry_mix = 15'd0;
        load_cfg(c);
        send_random(1, 0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_cfg(rand_cfg());
            send_random(PHASE_FRAMES, (ph % 3 == 0) ? 0 : 4);
        end

        settle_idle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
